### src/u16u8_pkg.sv
// ---------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and encoding helpers for the UTF-16 to UTF-8
// transcoder: command format between front and back, length codes, byte
// assembly.
// ---------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

    // Destination capacity after reset, in bytes (terminator included)
    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    // Command queue depth between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Surrogate ranges
    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;

    // Start of the supplementary planes
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // Sequence length codes (byte count minus one)
    localparam logic [1:0] LEN1 = 2'd0;
    localparam logic [1:0] LEN2 = 2'd1;
    localparam logic [1:0] LEN3 = 2'd2;
    localparam logic [1:0] LEN4 = 2'd3;

    // One unit of work for the back end: a code point to serialise, or the
    // closing zero byte with the running total.
    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  len_code;
        logic        term;
        logic        last;
        logic [15:0] total;
    } cmd_t;

    // Length code of the UTF-8 sequence for a code point
    function automatic logic [1:0] cp_len_code(input logic [20:0] cp);
        logic [1:0] code;
        if (cp < 21'h80) begin
            code = LEN1;
        end
        else if (cp < 21'h800) begin
            code = LEN2;
        end
        else if (cp < SUPP_BASE) begin
            code = LEN3;
        end
        else begin
            code = LEN4;
        end
        return code;
    endfunction

    // Byte number idx of the UTF-8 sequence for cp
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [1:0]  len_code,
                                             input logic [1:0]  idx);
        logic [7:0] b;
        b = 8'h00;
        case (len_code)
            LEN1: b = {1'b0, cp[6:0]};
            LEN2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            LEN3:
            begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### src/u16u8_front.sv
// ---------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks the held surrogate, byte count and full state,
// and turns each unit into zero, one or two commands for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module u16u8_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [15:0]       cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [15:0]       code_unit,
    input  wire logic              end_of_text,
    input  wire logic              q_full,
    output logic                   push_valid,
    output u16u8_pkg::cmd_t        push_cmd
);

    logic [15:0]     capacity_reg;
    logic [15:0]     held_high_reg, held_high_next;
    logic            held_valid_reg, held_valid_next;
    logic [15:0]     bw_reg, bw_next;
    logic            full_reg, full_next;
    logic            pend_valid_reg;
    u16u8_pkg::cmd_t pend_cmd_reg;

    logic            accept;
    logic            is_high, is_low, start;
    logic [15:0]     bw_a;
    logic            c1_valid, c2_valid;
    u16u8_pkg::cmd_t c1, c2;

    // Hold the input while a second command waits or the queue is full
    assign in_stall = pend_valid_reg || q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        is_high = code_unit inside {[u16u8_pkg::HIGH_SURR_LO:u16u8_pkg::HIGH_SURR_HI]};
        is_low  = code_unit inside {[u16u8_pkg::LOW_SURR_LO:u16u8_pkg::LOW_SURR_HI]};

        held_high_next  = held_high_reg;
        held_valid_next = held_valid_reg;
        bw_next         = bw_reg;
        full_next       = full_reg;
        bw_a            = bw_reg;
        start           = 1'b0;
        c1_valid        = 1'b0;
        c2_valid        = 1'b0;
        c1              = '0;
        c2              = '0;

        if (end_of_text)
        begin
            if (held_valid_reg)
            begin
                c1_valid    = 1'b1;
                c1.cp       = {5'b0, held_high_reg};
                c1.len_code = u16u8_pkg::LEN3;
                bw_a        = bw_reg + 16'd3;
            end
            c2_valid        = 1'b1;
            c2.term         = 1'b1;
            c2.len_code     = u16u8_pkg::LEN1;
            c2.total        = bw_a;
            held_high_next  = '0;
            held_valid_next = 1'b0;
            bw_next         = '0;
            full_next       = 1'b0;
        end
        else if (!full_reg)
        begin
            if (held_valid_reg)
            begin
                held_high_next  = '0;
                held_valid_next = 1'b0;
                if (is_low)
                begin
                    c2_valid    = 1'b1;
                    c2.cp       = u16u8_pkg::SUPP_BASE
                                + {1'b0, held_high_reg[9:0], code_unit[9:0]};
                    c2.len_code = u16u8_pkg::LEN4;
                    bw_next     = bw_reg + 16'd4;
                end
                else
                begin
                    // Lone high surrogate: flush as 3 bytes, then start anew
                    c1_valid    = 1'b1;
                    c1.cp       = {5'b0, held_high_reg};
                    c1.len_code = u16u8_pkg::LEN3;
                    bw_a        = bw_reg + 16'd3;
                    bw_next     = bw_a;
                    start       = 1'b1;
                end
            end
            else
            begin
                start = 1'b1;
            end

            if (start)
            begin
                if (({1'b0, bw_a} + 17'd4) >= {1'b0, capacity_reg})
                begin
                    full_next = 1'b1;
                end
                else if (is_high)
                begin
                    held_high_next  = code_unit;
                    held_valid_next = 1'b1;
                end
                else
                begin
                    c2_valid    = 1'b1;
                    c2.cp       = {5'b0, code_unit};
                    c2.len_code = u16u8_pkg::cp_len_code({5'b0, code_unit});
                    bw_next     = bw_a + {14'b0, c2.len_code} + 16'd1;
                end
            end
        end

        c2.last = 1'b1;
        c1.last = !c2_valid;
    end

    // Push the first command at once; park a second one for the next slot
    always_comb
    begin
        push_valid = 1'b0;
        push_cmd   = pend_cmd_reg;
        if (pend_valid_reg)
        begin
            push_valid = !q_full;
        end
        else if (accept)
        begin
            push_valid = c1_valid || c2_valid;
            push_cmd   = c1_valid ? c1 : c2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= u16u8_pkg::CAPACITY_RESET;
            held_high_reg  <= '0;
            held_valid_reg <= 1'b0;
            bw_reg         <= '0;
            full_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                held_high_reg  <= held_high_next;
                held_valid_reg <= held_valid_next;
                bw_reg         <= bw_next;
                full_reg       <= full_next;
                pend_valid_reg <= c1_valid && c2_valid;
            end
            else if (pend_valid_reg && !q_full)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_cmd_reg <= c2;
        end
    end

endmodule

`default_nettype wire

### src/u16u8_queue.sv
// ---------------------------------------------------------------------------
// u16u8_queue
// Short command FIFO between the front and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module u16u8_queue
#(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u16u8_pkg::cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output u16u8_pkg::cmd_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u16u8_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### src/u16u8_back.sv
// ---------------------------------------------------------------------------
// u16u8_back
// Serialises one command a time into UTF-8 bytes, one byte per cycle unless
// out_stall holds it, through a registered output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module u16u8_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_not_empty,
    input  wire u16u8_pkg::cmd_t q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           out_byte,
    output logic                 last,
    output logic [15:0]          total_bytes,
    output logic                 is_terminator
);

    logic            cur_valid_reg;
    u16u8_pkg::cmd_t cur_cmd_reg;
    logic [1:0]      idx_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic [15:0]     out_total_reg;
    logic            out_term_reg;

    logic            advance, final_byte;
    logic [7:0]      byte_next;

    assign final_byte = (idx_reg == cur_cmd_reg.len_code);
    assign advance    = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign q_pop      = q_not_empty && (!cur_valid_reg || (advance && final_byte));
    assign byte_next  = cur_cmd_reg.term ? 8'h00
                      : u16u8_pkg::utf8_byte(cur_cmd_reg.cp, cur_cmd_reg.len_code, idx_reg);

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last          = out_last_reg;
    assign total_bytes   = out_total_reg;
    assign is_terminator = out_term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (advance && final_byte)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_cmd_reg <= q_head;
        end
        if (advance)
        begin
            out_byte_reg  <= byte_next;
            out_last_reg  <= final_byte && cur_cmd_reg.last;
            out_total_reg <= cur_cmd_reg.term ? cur_cmd_reg.total : 16'd0;
            out_term_reg  <= cur_cmd_reg.term;
        end
    end

endmodule

`default_nettype wire

### src/utf16_to_utf8_transcoder_unit.sv
// ---------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// Converts a stream of UTF-16 code units into UTF-8 bytes with a bounded
// destination, joining surrogate pairs and closing with a zero byte.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Beat contents
//  -------  ---------  ---------------------  -----------------------------------
//  in       sink       in_valid / in_stall    code_unit, end_of_text
//  out      source     out_valid / out_stall  out_byte, last, total_bytes,
//                                             is_terminator
//  cfg      sink       cfg_wr_en              cfg_wr_data (capacity)
//
//  Output runs at one byte per cycle while out_stall is low; a code point takes
//  1 to 4 bytes from the back-end serialiser, which sets the sustained rate.
//  The front takes a unit per cycle, but holds the next when a unit yields two
//  commands: a flushed held high surrogate followed by a new code point or by
//  the closing byte. It also holds while the command queue is full.
//  Input to first byte: through the queue, serialiser and output registers.
//  Reset (rst_n low, asynchronous) clears control state; capacity returns to 256.
//  out_stall holds the output register; the command queue lets the front keep
//  taking units while the back end is held.
//
`default_nettype none

module utf16_to_utf8_transcoder_unit
#(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] code_unit,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic [15:0]      total_bytes,
    output logic             is_terminator
);

    logic            q_full, q_not_empty, q_pop, push_valid;
    u16u8_pkg::cmd_t push_cmd, q_head;

    // Front: classify units, keep surrogate and capacity state
    u16u8_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd)
    );

    // Queue: decouple classification from byte output
    u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Back: emit one UTF-8 byte per beat
    u16u8_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last          (last),
        .total_bytes   (total_bytes),
        .is_terminator (is_terminator)
    );

endmodule

`default_nettype wire

### src/u16u8_checker.sv
// ---------------------------------------------------------------------------
// u16u8_checker
// Port-level checks on the transcoder output stream.
// ---------------------------------------------------------------------------
`default_nettype none

module u16u8_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  out_byte,
    input wire logic        last,
    input wire logic [15:0] total_bytes,
    input wire logic        is_terminator
);

    // A held beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last)
            && $stable(total_bytes) && $stable(is_terminator))
        else $error("output beat changed while stalled");

    // The closing byte ends its item's beats
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_terminator |-> last && out_byte == 8'h00)
        else $error("terminator beat without last or with non-zero byte");

    // Length only travels on the closing byte
    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_terminator |-> total_bytes == 16'd0)
        else $error("total_bytes non-zero on a data beat");

    // A continuation byte never follows the last byte of an item
    a_cont_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last ##1 out_valid && !is_terminator
            |-> out_byte[7:6] != 2'b10)
        else $error("continuation byte starts an item");

endmodule

bind utf16_to_utf8_transcoder_unit u16u8_checker u_chk (.*);

`default_nettype wire
